// File: rtl/diff_drive_turn_state_steering_top_defines.svh
// Assertion macros for the steering block.
`ifndef DIFF_DRIVE_TURN_STATE_STEERING_TOP_DEFINES_SVH
`define DIFF_DRIVE_TURN_STATE_STEERING_TOP_DEFINES_SVH

// same-cycle implication
`define DDTS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddts: same-cycle check failed");

// next-cycle implication
`define DDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddts: next-cycle check failed");

`endif

// File: rtl/ddts_pkg.sv
package ddts_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_ROWS = 24;
    localparam int ATAN_IW   = 5;

    // CORDIC datapath
    localparam int CRD_W = 33;
    localparam int ANG_W = 31;

    // shared shift-subtract unit
    localparam int RD_W       = 20;
    localparam int STEP_CW    = 4;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 15;

    localparam logic [1:0] TURN_NONE = 2'd0;
    localparam logic [1:0] TURN_SOFT = 2'd1;
    localparam logic [1:0] TURN_HARD = 2'd2;

    localparam logic [1:0] CFG_HARD = 2'd0;
    localparam logic [1:0] CFG_SOFT = 2'd1;
    localparam logic [1:0] CFG_NONE = 2'd2;
    localparam logic [1:0] CFG_MAXV = 2'd3;

    typedef struct packed {
        logic start;
        logic div_mode;
    } t_rdiv_ctl;

    // atan(2^-i), pi = 2^31
    function automatic logic [31:0] atan_row(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // hysteresis: hard check, then soft, then none
    function automatic logic [1:0] next_turn(
        input logic [1:0]  cur,
        input logic [15:0] m,
        input logic [15:0] hard_th,
        input logic [15:0] soft_th,
        input logic [15:0] none_th
    );
        logic [1:0] st;
        st = cur;
        if (st == TURN_HARD && m <= soft_th) st = TURN_SOFT;
        if (st == TURN_SOFT) begin
            if (m > hard_th) st = TURN_HARD;
            else if (m <= none_th) st = TURN_NONE;
        end
        if (st != TURN_SOFT && st != TURN_HARD) begin
            if (m > hard_th) st = TURN_HARD;
            else if (m > none_th) st = TURN_SOFT;
            else st = TURN_NONE;
        end
        return st;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) r = 16'sh7FFF;
        else if (v < -17'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

// File: rtl/ddts_cordic.sv
module ddts_cordic
    import ddts_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [16:0]      i_ax,
    input  logic [16:0]      i_ay,
    output logic             o_busy,
    output logic [ANG_W-1:0] o_angle
);

    localparam int CW = $clog2(ANGLE_ITERATIONS);

    logic                    r_busy;
    logic [CW-1:0]           r_i;
    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic                    r_ax_zero, r_ay_zero;

    logic signed [CRD_W-1:0] x_sh, y_sh, atan_s;
    logic signed [CRD_W-1:0] n_x, n_y, n_z;

    always_comb begin
        x_sh   = r_x >>> r_i;
        y_sh   = r_y >>> r_i;
        atan_s = $signed({1'b0, atan_row(ATAN_IW'(r_i))});
        if (r_y > 0) begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_s;
        end else begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == CW'(ANGLE_ITERATIONS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x       <= $signed({2'b00, i_ax, 14'd0});
            r_y       <= $signed({2'b00, i_ay, 14'd0});
            r_z       <= '0;
            r_i       <= '0;
            r_ax_zero <= (i_ax == '0);
            r_ay_zero <= (i_ay == '0);
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + CW'(1);
        end
    end

    // axis cases are exact; otherwise clamp into 0..pi/2
    always_comb begin
        if (r_ay_zero) o_angle = '0;
        else if (r_ax_zero) o_angle = ANG_W'(1) << 30;
        else if (r_z < 0) o_angle = '0;
        else if (r_z > $signed(CRD_W'(1) << 30)) o_angle = ANG_W'(1) << 30;
        else o_angle = r_z[ANG_W-1:0];
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/ddts_rdiv.sv
module ddts_rdiv
    import ddts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rdiv_ctl   i_ctl,
    input  logic [31:0] i_operand,
    input  logic [16:0] i_divisor,
    output logic        o_busy,
    output logic [15:0] o_res
);

    logic               r_busy;
    logic               r_div;
    logic [STEP_CW-1:0] r_cnt;
    logic [RD_W-1:0]    r_rem;
    logic [31:0]        r_src;
    logic [15:0]        r_res;
    logic [16:0]        r_dsor;

    logic [RD_W-1:0] rem_sh, trial, diff;
    logic            ge;

    // one compare-subtract, fed as root digit or quotient digit
    always_comb begin
        if (r_div) begin
            rem_sh = {r_rem[RD_W-2:0], r_src[31]};
            trial  = RD_W'(r_dsor);
        end else begin
            rem_sh = {r_rem[RD_W-3:0], r_src[31:30]};
            trial  = {2'b00, r_res, 2'b01};
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div  <= i_ctl.div_mode;
            r_dsor <= i_divisor;
            r_res  <= '0;
            if (i_ctl.div_mode) begin
                // quotient is known to fit DIV_STEPS bits
                r_rem <= RD_W'(i_operand[31:DIV_STEPS]);
                r_src <= {i_operand[DIV_STEPS-1:0], (32 - DIV_STEPS)'(0)};
                r_cnt <= STEP_CW'(DIV_STEPS - 1);
            end else begin
                r_rem <= '0;
                r_src <= i_operand;
                r_cnt <= STEP_CW'(SQRT_STEPS - 1);
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_res <= {r_res[14:0], ge};
            r_src <= r_div ? {r_src[30:0], 1'b0} : {r_src[29:0], 2'b00};
            r_cnt <= r_cnt - STEP_CW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

// File: rtl/diff_drive_turn_state_steering_top.sv
// Differential-drive steering with a three-state turn mode. Each accepted beat
// carries a Q8.8 heading vector; the block finds its binary angle (pi = 32768)
// with an iterative CORDIC and its length with a bit-serial square root, moves
// the kept turn mode (none, soft, hard) with hysteresis, and returns one beat
// with both wheel speeds and the new mode. One heading is in flight at a time.
// The time for one heading is set by the shared shift-subtract unit (16 root
// steps, then 15 quotient steps for the soft-turn ratio); the CORDIC runs
// alongside the root and lengthens the wait only when ANGLE_ITERATIONS exceeds
// 19. Threshold and speed registers are written through the cfg port; the user
// must write them only while idle, and the block does not enforce it.
`include "diff_drive_turn_state_steering_top_defines.svh"

module diff_drive_turn_state_steering_top
    import ddts_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_heading_x,
    input  logic signed [15:0] i_heading_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic [1:0]         o_turn_mode
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_ROOT = 4'd3;
    localparam logic [3:0] ST_WAIT = 4'd4;
    localparam logic [3:0] ST_MODE = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_DIVW = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_hard, r_soft, r_none;
    logic [14:0] r_max;
    logic [1:0]  r_turn;

    logic        r_xneg, r_yneg;
    logic [16:0] r_ax, r_ay;
    logic [31:0] r_acc;
    logic [15:0] r_m;
    logic        r_pos;
    logic [14:0] r_base;
    logic [14:0] r_d;

    logic               r_out_valid;
    logic signed [15:0] r_left, r_right;
    logic [1:0]         r_mode;

    logic        in_acc, out_free;
    logic [16:0] in_ax, in_ay;
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;
    logic [31:0] ang_full, ang_rnd;
    logic [15:0] m_c;
    logic [1:0]  turn_c;

    logic             cd_busy;
    logic [ANG_W-1:0] cd_angle;
    t_rdiv_ctl        rd_ctl;
    logic [31:0]      rd_operand;
    logic             rd_busy;
    logic [15:0]      rd_res;

    logic signed [16:0] s1, s2, sl, sr;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_ax = i_heading_x[15] ? (17'd0 - {i_heading_x[15], i_heading_x})
                                   : {1'b0, i_heading_x};
    assign in_ay = i_heading_y[15] ? (17'd0 - {i_heading_y[15], i_heading_y})
                                   : {1'b0, i_heading_y};

    ddts_cordic #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_ax    (in_ax),
        .i_ay    (in_ay),
        .o_busy  (cd_busy),
        .o_angle (cd_angle)
    );

    always_comb begin
        rd_ctl.start    = (r_state == ST_ROOT) || (r_state == ST_DIV);
        rd_ctl.div_mode = (r_state == ST_DIV);
        // 2*base*m + hard, rounded quotient over 2*hard
        rd_operand = (r_state == ST_DIV) ? ({r_acc[30:0], 1'b0} + {16'd0, r_hard})
                                         : r_acc;
    end

    ddts_rdiv u_rdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rd_ctl),
        .i_operand (rd_operand),
        .i_divisor ({r_hard, 1'b0}),
        .o_busy    (rd_busy),
        .o_res     (rd_res)
    );

    // one multiplier: squares, then base * m
    always_comb begin
        case (r_state)
            ST_SQX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            ST_SQY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            default: begin
                mul_a = {2'b00, r_base};
                mul_b = {1'b0, r_m};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // unfold by the sign of x into 0..pi, then round to 16-bit binary angle
    always_comb begin
        ang_full = r_xneg ? (32'h8000_0000 - {1'b0, cd_angle}) : {1'b0, cd_angle};
        ang_rnd  = ang_full + 32'd32768;
        m_c      = ang_rnd[31:16];
        turn_c   = next_turn(r_turn, r_m, r_hard, r_soft, r_none);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_SQX;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_ROOT;
            ST_ROOT: n_state = ST_WAIT;
            ST_WAIT: if (!rd_busy && !cd_busy) n_state = ST_MODE;
            ST_MODE: begin
                if (turn_c == TURN_SOFT && r_hard != '0) n_state = ST_DIV;
                else n_state = ST_OUT;
            end
            ST_DIV:  n_state = ST_DIVW;
            ST_DIVW: if (!rd_busy) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_turn  <= TURN_NONE;
            r_hard  <= 16'd16384;
            r_soft  <= 16'd8192;
            r_none  <= 16'd1820;
            r_max   <= 15'd2560;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MODE) r_turn <= turn_c;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HARD: r_hard <= i_cfg_data;
                    CFG_SOFT: r_soft <= i_cfg_data;
                    CFG_NONE: r_none <= i_cfg_data;
                    CFG_MAXV: r_max  <= i_cfg_data[14:0];
                    default:  r_max  <= r_max;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_xneg <= i_heading_x[15];
                    r_yneg <= i_heading_y[15];
                    r_ax   <= in_ax;
                    r_ay   <= in_ay;
                end
            end
            ST_SQX: r_acc <= mul_p[31:0];
            ST_SQY: r_acc <= r_acc + mul_p[31:0];
            ST_WAIT: begin
                r_m    <= m_c;
                r_pos  <= (m_c != '0) && !r_yneg;
                r_base <= (rd_res < {1'b0, r_max}) ? rd_res[14:0] : r_max;
            end
            ST_MODE: begin
                r_acc <= mul_p[31:0];
                r_d   <= '0;
            end
            ST_DIVW: if (!rd_busy) r_d <= rd_res[14:0];
            default: r_acc <= r_acc;
        endcase
    end

    always_comb begin
        case (r_turn)
            TURN_SOFT: begin
                s1 = $signed({2'b00, r_base}) - $signed({2'b00, r_d});
                s2 = $signed({2'b00, r_base}) + $signed({2'b00, r_d});
            end
            TURN_HARD: begin
                s1 = -$signed({2'b00, r_max});
                s2 = $signed({2'b00, r_max});
            end
            default: begin
                s1 = $signed({2'b00, r_base});
                s2 = $signed({2'b00, r_base});
            end
        endcase
        // left turn puts the left wheel inside
        sl = r_pos ? s1 : s2;
        sr = r_pos ? s2 : s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_left  <= sat16(sl);
            r_right <= sat16(sr);
            r_mode  <= r_turn;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_turn_mode   = r_mode;

    `DDTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)
    `DDTS_ASSERT_HOLDS(a_rdiv_start_idle, i_clk, i_rst_n, rd_ctl.start, !rd_busy)
    `DDTS_ASSERT_HOLDS(a_hard_opposite, i_clk, i_rst_n,
        o_out_valid && o_turn_mode == TURN_HARD, o_left_speed == -o_right_speed)
    `DDTS_ASSERT_HOLDS(a_none_equal, i_clk, i_rst_n,
        o_out_valid && o_turn_mode == TURN_NONE, o_left_speed == o_right_speed)

endmodule
